>>> rtl/fhpa_pkg.sv
// Package for the handle pool allocator.
// Holds handle widths, pool limit, command and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fhpa_pkg;

	localparam int HANDLE_W     = 8;
	localparam int HANDLE_SPACE = 1 << HANDLE_W;
	localparam int CNT_W        = HANDLE_W + 1;
	localparam int POOL_SIZE    = 256;
	localparam int POOL_LIMIT   = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_TRY   = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [CNT_W-1:0]    count_t;

endpackage

`default_nettype wire

>>> rtl/fhpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fhpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/fifo_handle_pool_allocator.sv
// Handle pool allocator top level: FIFO free list and allocated map in RAM.
// Depends on fhpa_pkg and fhpa_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Fields
// req      req_valid/req_stall  cmd, release_handle
// rsp      rsp_valid/rsp_stall  granted_handle, status
//
// An item is read from both RAMs at accept and resolved in the next cycle,
// where its result loads the output register once that is not stalled; no
// new item is accepted until the result has loaded the output register.
// Reset clears pointers, counters and the map valid bits at once.
// A stalled result holds the output register and stalls req behind it.

module fifo_handle_pool_allocator (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [1:0]        cmd,
	input  wire fhpa_pkg::handle_t release_handle,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output fhpa_pkg::handle_t      granted_handle,
	output logic [1:0]             status
);

	import fhpa_pkg::*;

	localparam count_t LIMIT = CNT_W'(POOL_LIMIT);
	localparam count_t SPACE = CNT_W'(HANDLE_SPACE);

	logic                    accept;
	logic                    vld_s1;
	logic [1:0]              cmd_s1;
	handle_t                 rel_s1;
	handle_t                 head_q;
	handle_t                 tail_q;
	count_t                  count_q;
	count_t                  fresh_q;
	logic [HANDLE_SPACE-1:0] map_vld_q;
	logic                    rsp_valid_q;
	handle_t                 grant_q;
	logic [1:0]              status_q;

	handle_t    fifo_rdata;
	logic [0:0] map_rdata;
	logic       map_bit;
	logic       out_load;
	handle_t    grant;
	logic [1:0] st;
	logic       pop;
	logic       push;
	logic       fresh;
	logic       map_we;
	handle_t    map_waddr;

	assign req_stall = vld_s1 | (rsp_valid_q & rsp_stall);
	assign accept    = req_valid & ~req_stall;
	assign out_load  = vld_s1 & (~rsp_valid_q | ~rsp_stall);
	assign map_bit   = map_vld_q[rel_s1] & map_rdata[0];

	always_comb begin
		grant = '0;
		st    = ST_OK;
		pop   = 1'b0;
		push  = 1'b0;
		fresh = 1'b0;
		unique case (cmd_s1) inside
			CMD_ALLOC, CMD_TRY: begin
				if (count_q != '0) begin
					grant = fifo_rdata;
					pop   = 1'b1;
				end else if (cmd_s1 == CMD_TRY) begin
					st = ST_EMPTY;
				end else if (fresh_q < LIMIT) begin
					grant = fresh_q[HANDLE_W-1:0];
					fresh = 1'b1;
				end else begin
					st = ST_EXHAUSTED;
				end
			end
			CMD_FREE: begin
				if ({1'b0, rel_s1} >= LIMIT || !map_bit || count_q >= SPACE) begin
					st = ST_NOT_ALLOC;
				end else begin
					push = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign map_we    = out_load & (pop | fresh | push);
	assign map_waddr = push ? rel_s1 : grant;

	fhpa_ram #(
		.WIDTH(HANDLE_W),
		.DEPTH(HANDLE_SPACE)
	) u_fifo_ram (
		.clk  (clk),
		.we   (out_load & push),
		.waddr(tail_q),
		.wdata(rel_s1),
		.re   (accept),
		.raddr(head_q),
		.rdata(fifo_rdata)
	);

	fhpa_ram #(
		.WIDTH(1),
		.DEPTH(HANDLE_SPACE)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(~push),
		.re   (accept),
		.raddr(release_handle),
		.rdata(map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			fresh_q     <= '0;
			map_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (out_load) begin
				vld_s1 <= 1'b0;
			end
			if (out_load) begin
				head_q  <= head_q + HANDLE_W'(pop);
				tail_q  <= tail_q + HANDLE_W'(push);
				count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
				fresh_q <= fresh_q + CNT_W'(fresh);
			end
			if (map_we) begin
				map_vld_q[map_waddr] <= 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			rel_s1 <= release_handle;
		end
		if (out_load) begin
			grant_q  <= grant;
			status_q <= st;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign granted_handle = grant_q;
	assign status         = status_q;

endmodule

`default_nettype wire
